// ===== hdl/quick_turn_drive_mixer_unit_defines.svh =====
// Assertion macros used by the checker file of the drive mixer.
`ifndef QUICK_TURN_DRIVE_MIXER_UNIT_DEFINES_SVH
`define QUICK_TURN_DRIVE_MIXER_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define QTDM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define QTDM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/qtdm_pkg.sv =====
// Types and constants shared by the quick-turn drive mixer modules.
package qtdm_pkg;

	// Field widths of the stream payloads.
	localparam int STICK_W = 11;
	localparam int DRIVE_W = 15;
	localparam int ACC_W   = 16;

	// Configuration port geometry and register indexes.
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_DEADBAND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WINDOW = 2'd2;

	// Register values after reset.
	localparam logic [CFG_W-1:0] RST_FILTER_ALPHA  = 13'd410;
	localparam logic [CFG_W-1:0] RST_TURN_DEADBAND = 13'd410;
	localparam logic [CFG_W-1:0] RST_FILTER_WINDOW = 13'd819;

	// Filter weight is Q0.12 whatever the data format.
	localparam logic [CFG_W-1:0] ALPHA_ONE  = 13'd4096;
	localparam int               ALPHA_BITS = 12;
	localparam int               ALPHA_HALF = 2048;

	// Raw joystick full scale is 2^9.
	localparam int STICK_SHIFT = 9;

	typedef struct packed {
		logic [CFG_W-1:0] filter_alpha;
		logic [CFG_W-1:0] turn_deadband;
		logic [CFG_W-1:0] filter_window;
	} cfg_t;

	typedef struct packed {
		logic                      quick_turn;
		logic signed [DRIVE_W-1:0] right_drive;
		logic signed [DRIVE_W-1:0] left_drive;
	} result_t;

endpackage

// ===== hdl/qtdm_cfg_regs.sv =====
// Configuration register file of the drive mixer.
module qtdm_cfg_regs
	import qtdm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Write the addressed register; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_alpha  <= RST_FILTER_ALPHA;
			cfg_q.turn_deadband <= RST_TURN_DEADBAND;
			cfg_q.filter_window <= RST_FILTER_WINDOW;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_FILTER_ALPHA:  cfg_q.filter_alpha  <= cfg_wdata;
				CFG_TURN_DEADBAND: cfg_q.turn_deadband <= cfg_wdata;
				CFG_FILTER_WINDOW: cfg_q.filter_window <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/qtdm_core.sv =====
// Combinational mixing datapath: scaling, quick-stop filter, mixing and clamping.
module qtdm_core
	import qtdm_pkg::*;
#(
	parameter int FRAC_BITS = 12
)
(
	input  logic signed [STICK_W-1:0] stick_forward,
	input  logic signed [STICK_W-1:0] stick_turn,
	input  cfg_t                      cfg,
	input  logic signed [ACC_W-1:0]   acc,
	output logic signed [ACC_W-1:0]   acc_next,
	output result_t                   result
);

	// Scaled input width, product width, filter sum width, mixing width.
	localparam int RW  = STICK_W + FRAC_BITS;
	localparam int PW  = 2 * RW;
	localparam int TW  = RW + 15;
	localparam int MW  = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 8;
	localparam int ONE = 2 ** FRAC_BITS;
	localparam int LIM = 3 * ONE;
	localparam int HI  = (LIM < 16383) ? LIM : 16383;
	localparam int LO  = (-LIM > -16384) ? -LIM : -16384;

	logic signed [RW-1:0]   fwd_ext, turn_ext, fwd_sh, turn_sh, fwd, rot;
	logic        [RW-1:0]   afwd;
	logic                   quick, in_window;
	logic        [CFG_W-1:0] alpha_sat, beta;
	logic signed [CFG_W:0]  alpha_s, beta_s;
	logic signed [29:0]     p_acc;
	logic signed [RW+13:0]  p_rot;
	logic signed [TW-1:0]   t_sum, t_rnd;
	logic signed [ACC_W-1:0] acc_filt, acc_dec;
	logic signed [PW-1:0]   prod, prod_sh;
	logic signed [MW-1:0]   one_m, acc_m, fwd_m, ang;
	logic signed [MW-1:0]   left0, right0, left1, right1, left2, right2;

	// Scale raw axes to fixed point; the arithmetic shift floors.
	assign fwd_ext  = {{FRAC_BITS{stick_forward[STICK_W-1]}}, stick_forward};
	assign turn_ext = {{FRAC_BITS{stick_turn[STICK_W-1]}}, stick_turn};
	assign fwd_sh   = fwd_ext <<< FRAC_BITS;
	assign turn_sh  = turn_ext <<< FRAC_BITS;
	assign fwd      = fwd_sh >>> STICK_SHIFT;
	assign rot      = turn_sh >>> STICK_SHIFT;
	assign afwd     = fwd[RW-1] ? RW'(-fwd) : RW'(fwd);

	// Mode decisions against the two thresholds.
	assign quick     = afwd < {{(RW-CFG_W){1'b0}}, cfg.turn_deadband};
	assign in_window = afwd < {{(RW-CFG_W){1'b0}}, cfg.filter_window};

	// Quick-stop low-pass filter, rounded half up and saturated.
	assign alpha_sat = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
	assign beta      = ALPHA_ONE - alpha_sat;
	assign alpha_s   = {1'b0, alpha_sat};
	assign beta_s    = {1'b0, beta};
	assign p_acc     = beta_s * acc;
	assign p_rot     = alpha_s * rot;
	assign t_sum     = TW'(p_acc) + TW'(p_rot) + TW'(ALPHA_HALF);
	assign t_rnd     = t_sum >>> ALPHA_BITS;

	always_comb begin
		if (t_rnd > TW'(32767)) begin
			acc_filt = 16'sh7fff;
		end else if (t_rnd < TW'(-32768)) begin
			acc_filt = 16'sh8000;
		end else begin
			acc_filt = t_rnd[ACC_W-1:0];
		end
	end

	// Accumulator decays one unit toward zero, or clears inside one unit.
	assign one_m = MW'(ONE);
	assign acc_m = MW'(acc);

	always_comb begin
		if (acc_m > one_m) begin
			acc_dec = ACC_W'(acc_m - one_m);
		end else if (acc_m < -one_m) begin
			acc_dec = ACC_W'(acc_m + one_m);
		end else begin
			acc_dec = '0;
		end
	end

	always_comb begin
		if (!quick) begin
			acc_next = acc_dec;
		end else if (in_window) begin
			acc_next = acc_filt;
		end else begin
			acc_next = acc;
		end
	end

	// Angular term: scaled turn in quick-turn mode, else scaled product less accumulator.
	assign prod    = $signed(afwd) * rot;
	assign prod_sh = prod >>> FRAC_BITS;
	assign ang     = quick ? MW'(rot) : MW'(prod_sh) - acc_m;

	// Arcade mix.
	assign fwd_m  = MW'(fwd);
	assign left0  = -fwd_m - ang;
	assign right0 = -fwd_m + ang;

	// In quick-turn mode the excess beyond one unit moves to the other side.
	always_comb begin
		left1  = left0;
		right1 = right0;
		if (quick) begin
			if (left0 > one_m) begin
				right1 = right0 - (left0 - one_m);
				left1  = one_m;
			end else if (right0 > one_m) begin
				left1  = left0 - (right0 - one_m);
				right1 = one_m;
			end else if (left0 < -one_m) begin
				right1 = right0 - (left0 + one_m);
				left1  = -one_m;
			end else if (right0 < -one_m) begin
				left1  = left0 - (right0 + one_m);
				right1 = -one_m;
			end
		end
	end

	// Saturate both sides to three units and to the output field.
	always_comb begin
		if (left1 > MW'(HI)) begin
			left2 = MW'(HI);
		end else if (left1 < MW'(LO)) begin
			left2 = MW'(LO);
		end else begin
			left2 = left1;
		end
		if (right1 > MW'(HI)) begin
			right2 = MW'(HI);
		end else if (right1 < MW'(LO)) begin
			right2 = MW'(LO);
		end else begin
			right2 = right1;
		end
	end

	assign result.left_drive  = left2[DRIVE_W-1:0];
	assign result.right_drive = right2[DRIVE_W-1:0];
	assign result.quick_turn  = quick;

endmodule

// ===== hdl/quick_turn_drive_mixer_unit.sv =====
// An input transfer is captured in the input register, then mixed and captured in the result
// register, from which it is offered on the master side.
// Throughput: one sample per cycle unless the master side stalls; the input register,
// the mixing logic and the result register with the quick-stop accumulator form one pass per sample.
// Reset: arst_n clears the pipeline valid flags and the accumulator at once and
// loads the configuration registers with their reset values.
module quick_turn_drive_mixer_unit
	import qtdm_pkg::*;
#(
	parameter int FRAC_BITS = 12
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// Bits from 0: stick_forward[10:0], stick_turn[21:11], zero pad [23:22].
	input  logic [23:0]          s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// Bits from 0: left_drive[14:0], right_drive[29:15], zero pad [31:30].
	output logic [31:0]          m_axis_tdata,
	// Bit 0: quick_turn.
	output logic                 m_axis_tuser
);

	cfg_t                      cfg;
	logic                      valid_s1;
	logic signed [STICK_W-1:0] fwd_s1, turn_s1;
	logic                      out_valid_q;
	result_t                   res_q, res;
	logic signed [ACC_W-1:0]   acc_q, acc_next;
	logic                      advance, in_xfer;

	qtdm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	qtdm_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.stick_forward (fwd_s1),
		.stick_turn    (turn_s1),
		.cfg           (cfg),
		.acc           (acc_q),
		.acc_next      (acc_next),
		.result        (res)
	);

	// The sample moves on when the result register is empty or being drained.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			fwd_s1  <= s_axis_tdata[STICK_W-1:0];
			turn_s1 <= s_axis_tdata[2*STICK_W-1:STICK_W];
		end
	end

	// Result register valid flag and quick-stop accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				acc_q       <= acc_next;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.right_drive, res_q.left_drive};
	assign m_axis_tuser  = res_q.quick_turn;

endmodule

// ===== hdl/qtdm_checker.sv =====
// Port-level checker of the drive mixer and its bind to the top level.
`include "quick_turn_drive_mixer_unit_defines.svh"

module qtdm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// A stalled result holds its payload.
	`QTDM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// The input side only stalls when both stages are full and the output is blocked.
	`QTDM_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

	// Reset leaves no result pending.
	`QTDM_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !m_axis_tvalid && s_axis_tready, "pipeline not empty in reset")

endmodule

bind quick_turn_drive_mixer_unit qtdm_checker u_qtdm_checker (.*);
